// ===== rtl/core/tmsg_pkg.sv =====
// shared constants for the toroidal moore stencil gather core
package tmsg_pkg;

  localparam int unsigned MAX_CELLS = 4096;
  localparam int unsigned WORD_BITS = 32;

  localparam int unsigned ADDR_W  = $clog2(MAX_CELLS);
  localparam int unsigned NODE_W  = 12;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned ARITH_W = LEN_W + 1;
  localparam int unsigned NBR_CNT = 9;
  localparam int unsigned SLOT_W  = $clog2(NBR_CNT);

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_CENTRE  = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  localparam logic CFG_ROW_LENGTH = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(64);
  localparam logic [LEN_W-1:0] NODE_COUNT_RESET = LEN_W'(4096);

  // neighbour rows relative to the centre
  localparam logic [1:0] ROW_ABOVE = 2'd0;
  localparam logic [1:0] ROW_SAME  = 2'd1;
  localparam logic [1:0] ROW_BELOW = 2'd2;

endpackage

// ===== rtl/core/tmsg_ram.sv =====
// generic single-port synchronous ram with registered read
module tmsg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tmsg_rem.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
module tmsg_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tmsg_pkg::NODE_W-1:0] dividend_i,
  input  logic [tmsg_pkg::LEN_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [tmsg_pkg::NODE_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(tmsg_pkg::NODE_W + 1);

  logic [tmsg_pkg::LEN_W-1:0]  rem_d, shifted;
  logic [tmsg_pkg::NODE_W-1:0] rem_q;
  logic [tmsg_pkg::NODE_W-1:0] sh_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q, done_q;

  always_comb begin
    shifted = {rem_q, sh_q[tmsg_pkg::NODE_W-1]};
    if (shifted >= divisor_i) begin
      rem_d = shifted - divisor_i;
    end else begin
      rem_d = shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(tmsg_pkg::NODE_W);
        rem_q  <= '0;
        sh_q   <= dividend_i;
      end else if (busy_q) begin
        // remainder stays below the divisor, so it fits the node width
        rem_q <= rem_d[tmsg_pkg::NODE_W-1:0];
        sh_q  <= {sh_q[tmsg_pkg::NODE_W-2:0], 1'b0};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/toroidal_moore_stencil_gather_core.sv =====
// top level: request sequencer, wrap address generation and field memory
// a load is written straight to the field memory; a bad node result passes the done state to the output
// a gather passes through start, the column split remainder, column setup, nine ram reads,
// capture and output load
// one item in work at a time: input stalls while a gather runs, and a waiting result stalls input
// after reset a clearing pass zeroes the field; row_length 64, node_count 4096
module toroidal_moore_stencil_gather_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [tmsg_pkg::LEN_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [tmsg_pkg::NODE_W-1:0]  node_i,
  input  logic [31:0]                  value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tmsg_pkg::NODE_W-1:0]  centre_index_o,
  output logic [tmsg_pkg::OUT_W-1:0]   north_west_o,
  output logic [tmsg_pkg::OUT_W-1:0]   north_o,
  output logic [tmsg_pkg::OUT_W-1:0]   north_east_o,
  output logic [tmsg_pkg::OUT_W-1:0]   west_o,
  output logic [tmsg_pkg::OUT_W-1:0]   centre_o,
  output logic [tmsg_pkg::OUT_W-1:0]   east_o,
  output logic [tmsg_pkg::OUT_W-1:0]   south_west_o,
  output logic [tmsg_pkg::OUT_W-1:0]   south_o,
  output logic [tmsg_pkg::OUT_W-1:0]   south_east_o,
  output logic                         bad_node_o
);

  localparam int unsigned AW = tmsg_pkg::ADDR_W;
  localparam int unsigned XW = tmsg_pkg::ARITH_W;
  localparam int unsigned NW = tmsg_pkg::NODE_W;
  localparam int unsigned SW = tmsg_pkg::SLOT_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_START, ST_DIV, ST_COLS, ST_READ, ST_LAST, ST_DONE
  } state_e;

  state_e state_q;

  logic [tmsg_pkg::LEN_W-1:0] row_length_q, node_count_q;
  logic [tmsg_pkg::LEN_W-1:0] n_eff, l_eff;
  logic [XW-1:0]              n_x, l_x;

  logic [AW-1:0]             clr_cnt_q;
  logic [NW-1:0]             centre_q;
  logic [NW-1:0]             col_q [3];
  logic [1:0]                rd_row_q, rd_col_q;
  logic [SW-1:0]             rd_slot_q, cap_slot_q;
  logic                      cap_valid_q;
  logic [tmsg_pkg::OUT_W-1:0] work_q [tmsg_pkg::NBR_CNT];
  logic [NW-1:0]             work_centre_q;
  logic                      work_bad_q;

  logic                      out_valid_q;
  logic [tmsg_pkg::OUT_W-1:0] out_q [tmsg_pkg::NBR_CNT];
  logic [NW-1:0]             out_centre_q;
  logic                      out_bad_q;

  logic                      in_xfer, out_xfer, out_free, node_ok;
  logic [XW-1:0]             next_ctr;

  logic                      rem_start, rem_done;
  logic [NW-1:0]             rem_val;

  logic [XW-1:0]             c_x, b_x, cl_x, cr_x, wi_x, ei_x;
  logic [XW-1:0]             rx, ry;
  logic [NW-1:0]             rd_addr;

  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [tmsg_pkg::WORD_BITS-1:0] ram_wdata, ram_rdata;

  // effective config, clamped
  always_comb begin
    if (node_count_q == '0) begin
      n_eff = tmsg_pkg::LEN_W'(1);
    end else if (node_count_q > tmsg_pkg::LEN_W'(tmsg_pkg::MAX_CELLS)) begin
      n_eff = tmsg_pkg::LEN_W'(tmsg_pkg::MAX_CELLS);
    end else begin
      n_eff = node_count_q;
    end
    if (row_length_q == '0) begin
      l_eff = tmsg_pkg::LEN_W'(1);
    end else if (row_length_q > n_eff) begin
      l_eff = n_eff;
    end else begin
      l_eff = row_length_q;
    end
  end

  assign n_x = XW'(n_eff);
  assign l_x = XW'(l_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= tmsg_pkg::ROW_LENGTH_RESET;
      node_count_q <= tmsg_pkg::NODE_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmsg_pkg::CFG_ROW_LENGTH: row_length_q <= cfg_data_i;
        tmsg_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign node_ok    = (XW'(node_i) < n_x);
  assign next_ctr   = XW'(centre_q) + XW'(1);

  assign rem_start = (state_q == ST_START);

  tmsg_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (centre_q),
    .divisor_i  (l_eff),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // left and right column neighbours within the centre's row
  always_comb begin
    c_x = XW'(rem_val);
    b_x = XW'(centre_q) - c_x;
    if (c_x == '0) begin
      cl_x = l_x - XW'(1);
    end else begin
      cl_x = c_x - XW'(1);
    end
    if (c_x + XW'(1) == l_x) begin
      cr_x = '0;
    end else begin
      cr_x = c_x + XW'(1);
    end
    wi_x = b_x + cl_x;
    if (wi_x >= n_x) begin
      wi_x = wi_x - n_x;
    end
    ei_x = b_x + cr_x;
    if (ei_x >= n_x) begin
      ei_x = ei_x - n_x;
    end
  end

  // row wrap for the read being issued
  always_comb begin
    rx = XW'(col_q[rd_col_q]);
    unique case (rd_row_q)
      tmsg_pkg::ROW_ABOVE: ry = rx + n_x - l_x;
      tmsg_pkg::ROW_BELOW: ry = rx + l_x;
      default:             ry = rx;
    endcase
    if (ry >= n_x) begin
      ry = ry - n_x;
    end
    rd_addr = ry[NW-1:0];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(rd_addr);
    ram_wdata = tmsg_pkg::WORD_BITS'(value_i);
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = '0;
    end else if (in_xfer && req_type_i == tmsg_pkg::REQ_LOAD && node_ok) begin
      ram_we   = 1'b1;
      ram_addr = AW'(node_i);
    end
  end

  tmsg_ram #(
    .WIDTH (tmsg_pkg::WORD_BITS),
    .DEPTH (tmsg_pkg::MAX_CELLS)
  ) u_field_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      centre_q    <= '0;
      rd_row_q    <= '0;
      rd_col_q    <= '0;
      rd_slot_q   <= '0;
      cap_slot_q  <= '0;
      cap_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_valid_q <= (state_q == ST_READ);
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      if (cap_valid_q) begin
        work_q[cap_slot_q] <= tmsg_pkg::OUT_W'(ram_rdata);
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(tmsg_pkg::MAX_CELLS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (req_type_i)
              tmsg_pkg::REQ_LOAD, tmsg_pkg::REQ_CENTRE: begin
                if (!node_ok) begin
                  for (int i = 0; i < tmsg_pkg::NBR_CNT; i++) begin
                    work_q[i] <= '0;
                  end
                  work_centre_q <= '0;
                  work_bad_q    <= 1'b1;
                  state_q       <= ST_DONE;
                end else if (req_type_i == tmsg_pkg::REQ_CENTRE) begin
                  centre_q <= node_i;
                  state_q  <= ST_START;
                end
              end
              tmsg_pkg::REQ_ADVANCE: begin
                if (next_ctr >= n_x) begin
                  centre_q <= '0;
                end else begin
                  centre_q <= next_ctr[NW-1:0];
                end
                state_q <= ST_START;
              end
              default: ;
            endcase
          end
        end
        ST_START: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_done) begin
            state_q <= ST_COLS;
          end
        end
        ST_COLS: begin
          col_q[0]      <= wi_x[NW-1:0];
          col_q[1]      <= centre_q;
          col_q[2]      <= ei_x[NW-1:0];
          work_centre_q <= centre_q;
          work_bad_q    <= 1'b0;
          rd_row_q      <= tmsg_pkg::ROW_ABOVE;
          rd_col_q      <= '0;
          rd_slot_q     <= '0;
          state_q       <= ST_READ;
        end
        ST_READ: begin
          cap_slot_q  <= rd_slot_q;
          rd_slot_q   <= rd_slot_q + SW'(1);
          if (rd_col_q == 2'd2) begin
            rd_col_q <= '0;
            rd_row_q <= rd_row_q + 2'd1;
          end else begin
            rd_col_q <= rd_col_q + 2'd1;
          end
          if (rd_slot_q == SW'(tmsg_pkg::NBR_CNT - 1)) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_q        <= work_q;
            out_centre_q <= work_centre_q;
            out_bad_q    <= work_bad_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign centre_index_o = out_centre_q;
  assign north_west_o   = out_q[0];
  assign north_o        = out_q[1];
  assign north_east_o   = out_q[2];
  assign west_o         = out_q[3];
  assign centre_o       = out_q[4];
  assign east_o         = out_q[5];
  assign south_west_o   = out_q[6];
  assign south_o        = out_q[7];
  assign south_east_o   = out_q[8];
  assign bad_node_o     = out_bad_q;

endmodule

// ===== test/tmsg_gather_checker.sv =====
`timescale 1ns / 1ps
// checker for the stencil gather core: tracks the field, predicts gathers, compares results
module tmsg_gather_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [tmsg_pkg::LEN_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    req_type_i,
  input  logic [tmsg_pkg::NODE_W-1:0]   node_i,
  input  logic [31:0]                   value_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [tmsg_pkg::NODE_W-1:0]   centre_index_i,
  input  logic [tmsg_pkg::OUT_W-1:0]    north_west_i,
  input  logic [tmsg_pkg::OUT_W-1:0]    north_i,
  input  logic [tmsg_pkg::OUT_W-1:0]    north_east_i,
  input  logic [tmsg_pkg::OUT_W-1:0]    west_i,
  input  logic [tmsg_pkg::OUT_W-1:0]    centre_i,
  input  logic [tmsg_pkg::OUT_W-1:0]    east_i,
  input  logic [tmsg_pkg::OUT_W-1:0]    south_west_i,
  input  logic [tmsg_pkg::OUT_W-1:0]    south_i,
  input  logic [tmsg_pkg::OUT_W-1:0]    south_east_i,
  input  logic                          bad_node_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  // nine neighbours in row order: above, same, below; each left, middle, right
  typedef struct packed {
    logic [tmsg_pkg::NODE_W-1:0]                       centre_index;
    logic [tmsg_pkg::NBR_CNT-1:0][tmsg_pkg::OUT_W-1:0] nbr;
    logic                                              bad_node;
  } gather_t;

  logic [tmsg_pkg::OUT_W-1:0]  field_words [tmsg_pkg::MAX_CELLS];
  logic [tmsg_pkg::NODE_W-1:0] centre_q;
  logic [tmsg_pkg::LEN_W-1:0]  row_len_q;
  logic [tmsg_pkg::LEN_W-1:0]  node_cnt_q;
  gather_t                     expected_gathers [$];
  gather_t                     got_res;
  gather_t                     exp_res;
  int unsigned                 mismatches;

  string nbr_names [tmsg_pkg::NBR_CNT] = '{"north_west", "north", "north_east", "west",
                                           "centre", "east", "south_west", "south",
                                           "south_east"};

  function automatic int unsigned torus_cells();
    int unsigned n;
    n = 32'(node_cnt_q);
    if (n < 1) n = 1;
    if (n > tmsg_pkg::MAX_CELLS) n = tmsg_pkg::MAX_CELLS;
    return n;
  endfunction

  task automatic gather_at(input logic [tmsg_pkg::NODE_W-1:0] ctr, output gather_t res);
    int unsigned n;
    int unsigned l;
    int unsigned col;
    int unsigned base;
    int unsigned a;
    int unsigned cols [3];
    n = torus_cells();
    l = (row_len_q == '0) ? 1 : 32'(row_len_q);
    if (l > n) l = n;
    col = 32'(ctr) % l;
    base = 32'(ctr) - col;
    cols[0] = base + (col + l - 1) % l;
    cols[1] = 32'(ctr);
    cols[2] = base + (col + 1) % l;
    // left and right columns may step past the end of a short last row
    if (cols[0] >= n) cols[0] -= n;
    if (cols[2] >= n) cols[2] -= n;
    res = '0;
    res.centre_index = ctr;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        a = cols[k];
        if (r == tmsg_pkg::ROW_ABOVE) a = a + n - l;
        else if (r == tmsg_pkg::ROW_BELOW) a = a + l;
        if (a >= n) a -= n;
        res.nbr[r * 3 + k] = field_words[a];
      end
    end
  endtask

  task automatic take_request(input logic [1:0] req,
                              input logic [tmsg_pkg::NODE_W-1:0] node,
                              input logic [31:0] val);
    int unsigned n;
    int unsigned nxt;
    gather_t res;
    n = torus_cells();
    res = '0;
    if (req == tmsg_pkg::REQ_NONE) return;
    if ((req == tmsg_pkg::REQ_LOAD || req == tmsg_pkg::REQ_CENTRE) && 32'(node) >= n) begin
      res.bad_node = 1'b1;
      expected_gathers.push_back(res);
      return;
    end
    if (req == tmsg_pkg::REQ_LOAD) begin
      field_words[node] = val;
      return;
    end
    if (req == tmsg_pkg::REQ_CENTRE) begin
      centre_q = node;
    end else begin
      // also wraps when the torus shrank below the old centre
      nxt = 32'(centre_q) + 1;
      centre_q = (nxt >= n) ? '0 : tmsg_pkg::NODE_W'(nxt);
    end
    gather_at(centre_q, res);
    expected_gathers.push_back(res);
  endtask

  task automatic flag_mismatch(input string what, input logic [tmsg_pkg::OUT_W-1:0] exp_v,
                               input logic [tmsg_pkg::OUT_W-1:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tmsg_pkg::MAX_CELLS; i++) field_words[i] = '0;
      centre_q = '0;
      row_len_q = tmsg_pkg::ROW_LENGTH_RESET;
      node_cnt_q = tmsg_pkg::NODE_COUNT_RESET;
      expected_gathers.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == tmsg_pkg::CFG_ROW_LENGTH) row_len_q = cfg_data_i;
        else node_cnt_q = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        got_res.centre_index = centre_index_i;
        got_res.nbr = {south_east_i, south_i, south_west_i, east_i, centre_i, west_i,
                       north_east_i, north_i, north_west_i};
        got_res.bad_node = bad_node_i;
        if (expected_gathers.size() == 0) begin
          $display("%0t: result with nothing expected, actual centre_index %h bad_node %b",
                   $time, centre_index_i, bad_node_i);
          mismatches++;
        end else begin
          exp_res = expected_gathers.pop_front();
          if (got_res.centre_index !== exp_res.centre_index)
            flag_mismatch("centre_index", tmsg_pkg::OUT_W'(exp_res.centre_index),
                          tmsg_pkg::OUT_W'(got_res.centre_index));
          for (int i = 0; i < tmsg_pkg::NBR_CNT; i++) begin
            if (got_res.nbr[i] !== exp_res.nbr[i])
              flag_mismatch(nbr_names[i], exp_res.nbr[i], got_res.nbr[i]);
          end
          if (got_res.bad_node !== exp_res.bad_node)
            flag_mismatch("bad_node", tmsg_pkg::OUT_W'(exp_res.bad_node),
                          tmsg_pkg::OUT_W'(got_res.bad_node));
        end
      end
      if (in_valid_i && !in_stall_i) take_request(req_type_i, node_i, value_i);
      fail_count_o <= mismatches;
      pending_o <= 32'(expected_gathers.size());
    end
  end

endmodule

// ===== test/tb_toroidal_moore_stencil_gather_core.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, request stimulus and verdict for the stencil gather core
module tb_toroidal_moore_stencil_gather_core;

  localparam int unsigned LIMIT_CYCLES  = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 300;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic                        cfg_idx = tmsg_pkg::CFG_ROW_LENGTH;
  logic [tmsg_pkg::LEN_W-1:0]  cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  req_type = tmsg_pkg::REQ_NONE;
  logic [tmsg_pkg::NODE_W-1:0] node = '0;
  logic [31:0]                 value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [tmsg_pkg::NODE_W-1:0] centre_index;
  logic [tmsg_pkg::OUT_W-1:0]  north_west, north, north_east, west, centre, east;
  logic [tmsg_pkg::OUT_W-1:0]  south_west, south, south_east;
  logic                        bad_node;

  int unsigned fail_count;
  int unsigned pending_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned cur_n = 4096;
  int unsigned cur_l = 64;
  int unsigned win_base = 0;
  bit          rx_idle_en = 1'b1;
  bit          hold_req = 1'b0;

  toroidal_moore_stencil_gather_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .node_i         (node),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .centre_index_o (centre_index),
    .north_west_o   (north_west),
    .north_o        (north),
    .north_east_o   (north_east),
    .west_o         (west),
    .centre_o       (centre),
    .east_o         (east),
    .south_west_o   (south_west),
    .south_o        (south),
    .south_east_o   (south_east),
    .bad_node_o     (bad_node)
  );

  tmsg_gather_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .req_type_i     (req_type),
    .node_i         (node),
    .value_i        (value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .centre_index_i (centre_index),
    .north_west_i   (north_west),
    .north_i        (north),
    .north_east_i   (north_east),
    .west_i         (west),
    .centre_i       (centre),
    .east_i         (east),
    .south_west_i   (south_west),
    .south_i        (south),
    .south_east_i   (south_east),
    .bad_node_i     (bad_node),
    .fail_count_o   (fail_count),
    .pending_o      (pending_cnt)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > LIMIT_CYCLES) begin
        $display("FAIL toroidal_moore_stencil_gather_core");
        $finish;
      end
    end
  end

  // result side: random stall bursts, quiet stretches, and one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 29)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [1:0] rt, input logic [tmsg_pkg::NODE_W-1:0] nd,
                           input logic [31:0] val, input bit gaps);
    in_valid <= 1'b1;
    req_type <= rt;
    node <= nd;
    value <= val;
    do @(posedge clk); while (in_stall);
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every gather came back and a trailing load is done
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic new_geometry(input int unsigned row, input int unsigned nodes);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= tmsg_pkg::CFG_ROW_LENGTH;
    cfg_data <= tmsg_pkg::LEN_W'(row);
    @(posedge clk);
    cfg_idx <= tmsg_pkg::CFG_NODE_COUNT;
    cfg_data <= tmsg_pkg::LEN_W'(nodes);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_n = (nodes < 1) ? 1 :
            ((nodes > tmsg_pkg::MAX_CELLS) ? tmsg_pkg::MAX_CELLS : nodes);
    cur_l = (row < 1) ? 1 : row;
    if (cur_l > cur_n) cur_l = cur_n;
    win_base = $urandom_range(0, cur_n - 1);
  endtask

  // mostly nodes in a small patch so loads land where gathers read
  function automatic logic [tmsg_pkg::NODE_W-1:0] pick_node();
    int unsigned span;
    int unsigned idx;
    span = 3 * cur_l + 2;
    if (span > 200) span = 200;
    if (span > cur_n) span = cur_n;
    case ($urandom_range(0, 9))
      0: idx = $urandom_range(0, 4095);
      1: idx = cur_n - 1 - $urandom_range(0, span - 1);
      2: idx = $urandom_range(0, span - 1);
      default: idx = (win_base + $urandom_range(0, span - 1)) % cur_n;
    endcase
    return tmsg_pkg::NODE_W'(idx);
  endfunction

  task automatic random_items(input int unsigned count, input bit gaps);
    logic [1:0] rt;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) rt = tmsg_pkg::REQ_LOAD;
      else if (pick < 13) rt = tmsg_pkg::REQ_CENTRE;
      else if (pick < 19) rt = tmsg_pkg::REQ_ADVANCE;
      else rt = tmsg_pkg::REQ_NONE;
      send_item(rt, pick_node(), $urandom(), gaps);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: 64 wide, 4096 cells; first gather sees the cleared field
    send_item(tmsg_pkg::REQ_ADVANCE, 12'd0, 32'h0, 1'b1);
    // fill the neighbourhood of cell 0, which wraps on both edges
    send_item(tmsg_pkg::REQ_LOAD, 12'd0, 32'hFFFF_FFFF, 1'b1);
    send_item(tmsg_pkg::REQ_LOAD, 12'd1, 32'h8000_0001, 1'b1);
    send_item(tmsg_pkg::REQ_LOAD, 12'd63, 32'hA5A5_A5A5, 1'b1);
    send_item(tmsg_pkg::REQ_LOAD, 12'd4032, 32'h5A5A_5A5A, 1'b1);
    send_item(tmsg_pkg::REQ_LOAD, 12'd4095, 32'h1357_9BDF, 1'b1);
    send_item(tmsg_pkg::REQ_LOAD, 12'd4033, 32'h2468_ACE0, 1'b1);
    send_item(tmsg_pkg::REQ_LOAD, 12'd64, 32'h7FFF_FFFE, 1'b1);
    send_item(tmsg_pkg::REQ_LOAD, 12'd127, 32'hDEAD_BEEF, 1'b1);
    send_item(tmsg_pkg::REQ_LOAD, 12'd65, 32'h0F0F_F0F0, 1'b1);
    send_item(tmsg_pkg::REQ_CENTRE, 12'd0, 32'h0, 1'b1);
    send_item(tmsg_pkg::REQ_CENTRE, 12'd4095, 32'h0, 1'b1);
    send_item(tmsg_pkg::REQ_ADVANCE, 12'd0, 32'h0, 1'b1);
    send_item(tmsg_pkg::REQ_NONE, 12'd4095, 32'hFFFF_FFFF, 1'b1);
    send_item(tmsg_pkg::REQ_CENTRE, 12'd4095, 32'h0, 1'b1);

    // smallest useful torus; the old centre is now past the end
    new_geometry(3, 9);
    send_item(tmsg_pkg::REQ_ADVANCE, 12'd0, 32'h0, 1'b1);
    send_item(tmsg_pkg::REQ_LOAD, 12'd9, 32'hFFFF_FFFF, 1'b1);
    send_item(tmsg_pkg::REQ_LOAD, 12'd4095, 32'hFFFF_FFFF, 1'b1);
    send_item(tmsg_pkg::REQ_CENTRE, 12'd4095, 32'h0, 1'b1);
    send_item(tmsg_pkg::REQ_CENTRE, 12'd8, 32'h0, 1'b1);
    send_item(tmsg_pkg::REQ_ADVANCE, 12'd0, 32'h0, 1'b1);
    random_items(160, 1'b1);

    new_geometry(0, 0);
    random_items(60, 1'b1);
    new_geometry(8191, 8191);
    random_items(110, 1'b1);
    new_geometry(1, 4096);
    random_items(110, 1'b1);

    // long hold on the result side while requests keep coming
    new_geometry(5, 17);
    random_items(100, 1'b1);
    hold_req = 1'b1;
    random_items(40, 1'b0);
    random_items(60, 1'b1);

    new_geometry(100, 50);
    random_items(150, 1'b1);
    new_geometry(4096, 4096);
    random_items(90, 1'b1);
    new_geometry(7, 4);
    random_items(100, 1'b1);
    repeat (3) begin
      new_geometry($urandom_range(1, 20), $urandom_range(9, 80));
      random_items(150, 1'b1);
    end

    // last stretch at full rate on both sides
    new_geometry(6, 30);
    rx_idle_en = 1'b0;
    random_items(200, 1'b0);

    wait_idle();
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("PASS toroidal_moore_stencil_gather_core");
    end else begin
      $display("FAIL toroidal_moore_stencil_gather_core");
    end
    $finish;
  end

endmodule
